@@ sv/kmst_pkg.sv @@
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared constants for the spanning tree search block.
// ----------------------------------------------------------------------------
package kmst_pkg;

   // Operation codes of an input word.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   // Result kinds.
   localparam logic KIND_EDGE    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Fixed field widths.
   localparam int VERT_W = 4;
   localparam int COST_W = 20;
   localparam int CNT_W  = 4;
   localparam int VCFG_W = 5;
   localparam int WOUT_W = 16;

   // Size of the vertex tables, set by the vertex field width.
   localparam int MAX_VERTICES = 16;

endpackage

@@ sv/kmst_edge_mem.sv @@
// ----------------------------------------------------------------------------
// kmst_edge_mem
// Edge store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module kmst_edge_mem #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 24,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem [DEPTH];

   // Synchronous write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

@@ sv/kruskal_mst_union_find_top.sv @@
// ----------------------------------------------------------------------------
// kruskal_mst_union_find_top
// Kruskal minimum spanning tree search over a loaded edge store, with
// union-find (path compression, union by size) on a small vertex table.
// ----------------------------------------------------------------------------
//  channel   ports                          direction
//  request   start, busy, req_*             in (busy is out)
//  result    rsp_valid, rsp_*               out, one cycle each
//  config    csr_we, csr_vertex_count       in
//
// A load word is stored while idle and the store is not full. A run word
// does, per round, one scan of the edge store through the one read port, a
// pick step, then for each endpoint a find walk up the parent chain and a
// compression walk over its path, a union step, and an emit step when the
// edge joins two sets. The summary word follows at the end of the run.
// Reset is synchronous and active high; results cannot be stalled.
module kruskal_mst_union_find_top #(
   parameter int MAX_EDGES    = 64,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_op,
   input  logic [kmst_pkg::VERT_W-1:0]  req_edge_u,
   input  logic [kmst_pkg::VERT_W-1:0]  req_edge_v,
   input  logic [WEIGHT_BITS-1:0]       req_edge_weight,
   input  logic                         csr_we,
   input  logic [kmst_pkg::VCFG_W-1:0]  csr_vertex_count,
   output logic                         rsp_valid,
   output logic                         rsp_kind,
   output logic [kmst_pkg::VERT_W-1:0]  rsp_tree_u,
   output logic [kmst_pkg::VERT_W-1:0]  rsp_tree_v,
   output logic [kmst_pkg::WOUT_W-1:0]  rsp_tree_weight,
   output logic [kmst_pkg::COST_W-1:0]  rsp_total_cost,
   output logic [kmst_pkg::CNT_W-1:0]   rsp_edge_total,
   output logic                         rsp_spanning,
   output logic                         rsp_last
);

   localparam int MAX_VERTICES = kmst_pkg::MAX_VERTICES;
   localparam int VW   = kmst_pkg::VERT_W;
   localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EC_W = $clog2(MAX_EDGES + 1);
   localparam int VI_W = $clog2(MAX_VERTICES);
   localparam int SZ_W = $clog2(MAX_VERTICES + 1);
   localparam int ED_W = 2 * VW + WEIGHT_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_PICK, S_FIND, S_COMP, S_UNION, S_EMIT, S_DONE
   } state_type;

   state_type state_ff;
   logic [kmst_pkg::VCFG_W-1:0] vcount_ff;
   logic [EC_W-1:0]  stored_ff;
   logic [EC_W-1:0]  scan_ff;
   logic             rd_vld_ff;
   logic [EA_W-1:0]  rd_idx_ff;
   logic             found_ff;
   logic [EA_W-1:0]  best_ff;
   logic [ED_W-1:0]  best_data_ff;
   logic [VI_W-1:0]  parent_ff [MAX_VERTICES];
   logic [SZ_W-1:0]  size_ff [MAX_VERTICES];
   logic             side_ff;
   logic [VI_W-1:0]  walk_ff;
   logic [VI_W-1:0]  ru_ff;
   logic [VI_W-1:0]  rv_ff;
   logic [VI_W-1:0]  comp_ff;
   logic [VW:0]      steps_ff;
   logic [kmst_pkg::COST_W-1:0] cost_ff;
   logic [kmst_pkg::CNT_W-1:0]  acc_ff;
   logic [VW:0]      nvert;
   logic [VW:0]      need;
   logic             rd_unused;
   logic             rd_used;
   logic [ED_W:0]    rd_data;
   logic [ED_W:0]    wr_data;
   logic [EA_W-1:0]  wr_addr;
   logic             mem_we;
   logic             load_we;
   logic             mark_we;
   logic [EA_W-1:0]  rd_addr;
   logic [VW-1:0]    rd_u, rd_v, b_u, b_v;
   logic [WEIGHT_BITS-1:0] rd_w, b_w;
   logic             rd_ok;
   logic [VI_W-1:0]  rs, rl;

   // Effective vertex count and edges needed for a spanning tree.
   always_comb begin
      if (vcount_ff == '0) begin
         nvert = (VW+1)'(1);
      end else if (32'(vcount_ff) > MAX_VERTICES) begin
         nvert = (VW+1)'(MAX_VERTICES);
      end else begin
         nvert = (VW+1)'(vcount_ff);
      end
      need = nvert - (VW+1)'(1);
   end

   assign busy    = (state_ff != S_IDLE);
   assign load_we = start && !busy && (req_op == kmst_pkg::OP_LOAD)
                    && (32'(stored_ff) < MAX_EDGES);
   assign mark_we = (state_ff == S_PICK) && found_ff;
   assign rd_addr = scan_ff[EA_W-1:0];

   // Each stored word carries its used flag. A load writes it clear, and the
   // pick of an edge writes the word back with the flag set. The store is
   // emptied after every run, so each run only sees freshly loaded words.
   assign mem_we  = load_we || mark_we;
   assign wr_addr = mark_we ? best_ff : stored_ff[EA_W-1:0];
   assign wr_data = mark_we ? {1'b1, best_data_ff}
                            : {1'b0, req_edge_u, req_edge_v, req_edge_weight};

   kmst_edge_mem #(.DEPTH(MAX_EDGES), .DATA_W(ED_W+1), .ADDR_W(EA_W)) u_mem (
      .clock      (clock),
      .wr_en      (mem_we),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // Field split of the read word and of the chosen edge.
   assign {rd_used, rd_u, rd_v, rd_w} = rd_data;
   assign {b_u, b_v, b_w}    = best_data_ff;
   assign rd_unused = !rd_used;
   assign rd_ok = rd_vld_ff && rd_unused && ((VW+1)'(rd_u) < nvert)
                  && ((VW+1)'(rd_v) < nvert);

   // Union roles: the smaller-or-equal set goes under the other root.
   always_comb begin
      if (size_ff[ru_ff] > size_ff[rv_ff]) begin
         rs = rv_ff;
         rl = ru_ff;
      end else begin
         rs = ru_ff;
         rl = rv_ff;
      end
   end

   // Main sequencer with registered result word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         vcount_ff <= kmst_pkg::VCFG_W'(16);
         stored_ff <= '0;
         rsp_valid <= 1'b0;
         rd_vld_ff <= 1'b0;
         for (int i = 0; i < MAX_VERTICES; i++) begin
            parent_ff[i] <= VI_W'(i);
            size_ff[i]   <= SZ_W'(1);
         end
      end else begin
         rsp_valid <= 1'b0;
         if (csr_we) begin
            vcount_ff <= csr_vertex_count;
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  if (req_op == kmst_pkg::OP_LOAD) begin
                     if (load_we) begin
                        stored_ff <= stored_ff + EC_W'(1);
                     end
                  end else begin
                     for (int i = 0; i < MAX_VERTICES; i++) begin
                        parent_ff[i] <= VI_W'(i);
                        size_ff[i]   <= SZ_W'(1);
                     end
                     cost_ff <= '0;
                     acc_ff  <= '0;
                     if (need == '0) begin
                        state_ff <= S_DONE;
                     end else begin
                        scan_ff   <= '0;
                        found_ff  <= 1'b0;
                        rd_vld_ff <= 1'b0;
                        state_ff  <= S_SCAN;
                     end
                  end
               end
            end
            S_SCAN: begin
               // One read issued per cycle; compare the word from last cycle.
               rd_vld_ff <= (scan_ff < stored_ff);
               rd_idx_ff <= rd_addr;
               if (scan_ff < stored_ff) begin
                  scan_ff <= scan_ff + EC_W'(1);
               end
               if (rd_ok && (!found_ff || rd_w < b_w)) begin
                  found_ff     <= 1'b1;
                  best_ff      <= rd_idx_ff;
                  best_data_ff <= rd_data[ED_W-1:0];
               end
               if (!(scan_ff < stored_ff) && !rd_vld_ff) begin
                  state_ff <= S_PICK;
               end
            end
            S_PICK: begin
               if (!found_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  side_ff  <= 1'b0;
                  walk_ff  <= VI_W'(b_u);
                  comp_ff  <= VI_W'(b_u);
                  steps_ff <= '0;
                  state_ff <= S_FIND;
               end
            end
            S_FIND: begin
               // One step up the parent chain per cycle.
               if (parent_ff[walk_ff] != walk_ff && 32'(steps_ff) < MAX_VERTICES) begin
                  walk_ff  <= parent_ff[walk_ff];
                  steps_ff <= steps_ff + (VW+1)'(1);
               end else begin
                  steps_ff <= '0;
                  state_ff <= S_COMP;
               end
            end
            S_COMP: begin
               // Path compression, one vertex per cycle.
               if (comp_ff != walk_ff && 32'(steps_ff) < MAX_VERTICES) begin
                  parent_ff[comp_ff] <= walk_ff;
                  comp_ff  <= parent_ff[comp_ff];
                  steps_ff <= steps_ff + (VW+1)'(1);
               end else if (!side_ff) begin
                  ru_ff    <= walk_ff;
                  side_ff  <= 1'b1;
                  walk_ff  <= VI_W'(b_v);
                  comp_ff  <= VI_W'(b_v);
                  steps_ff <= '0;
                  state_ff <= S_FIND;
               end else begin
                  rv_ff    <= walk_ff;
                  state_ff <= S_UNION;
               end
            end
            S_UNION: begin
               scan_ff   <= '0;
               found_ff  <= 1'b0;
               rd_vld_ff <= 1'b0;
               if (ru_ff == rv_ff) begin
                  state_ff <= S_SCAN;
               end else begin
                  parent_ff[rs] <= rl;
                  size_ff[rl]   <= size_ff[rl] + size_ff[rs];
                  cost_ff <= cost_ff + kmst_pkg::COST_W'(b_w);
                  acc_ff  <= acc_ff + kmst_pkg::CNT_W'(1);
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               rsp_valid       <= 1'b1;
               rsp_kind        <= kmst_pkg::KIND_EDGE;
               rsp_tree_u      <= b_u;
               rsp_tree_v      <= b_v;
               rsp_tree_weight <= kmst_pkg::WOUT_W'(b_w);
               rsp_total_cost  <= cost_ff;
               rsp_edge_total  <= acc_ff;
               rsp_spanning    <= 1'b0;
               rsp_last        <= 1'b0;
               state_ff <= ((VW+1)'(acc_ff) < need) ? S_SCAN : S_DONE;
            end
            S_DONE: begin
               rsp_valid       <= 1'b1;
               rsp_kind        <= kmst_pkg::KIND_SUMMARY;
               rsp_tree_u      <= '0;
               rsp_tree_v      <= '0;
               rsp_tree_weight <= '0;
               rsp_total_cost  <= cost_ff;
               rsp_edge_total  <= acc_ff;
               rsp_spanning    <= ((VW+1)'(acc_ff) == need);
               rsp_last        <= 1'b1;
               stored_ff       <= '0;
               state_ff        <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
